// File: rtl/core/ssss_pkg.sv
// ----------------------------------------------------------------------------
// ssss_pkg - shared types and constants of the seven-segment scan serializer
// Digit record, frame geometry and the segment pattern table.
// ----------------------------------------------------------------------------
package ssss_pkg;

  localparam int VALUE_W    = 14;
  localparam int DIGIT_W    = 4;
  localparam int FRAME_BITS = 24;
  localparam int POS_W      = 5;
  localparam int ROW_W      = 4;
  localparam int MASK_W     = 8;
  localparam int SPLIT_LAT  = 7;   // register stages in the digit split

  localparam logic [VALUE_W-1:0] MAX_VALUE = 14'd9999;
  localparam logic [7:0]         DP_BIT    = 8'h04;
  localparam logic [POS_W-1:0]   LAST_POS  = 5'd23;
  localparam logic [ROW_W-1:0]   ROW_FIRST = 4'd1;
  localparam logic [ROW_W-1:0]   ROW_LAST  = 4'd8;

  typedef struct packed {
    logic [DIGIT_W-1:0] thousands;
    logic [DIGIT_W-1:0] hundreds;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
  } digits_t;

  typedef struct packed {
    logic load_ready;
    logic busy;
  } ser_status_t;

  function automatic logic [7:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'hF9;
      4'd1:    p = 8'h81;
      4'd2:    p = 8'hBA;
      4'd3:    p = 8'hAB;
      4'd4:    p = 8'hC3;
      4'd5:    p = 8'h6B;
      4'd6:    p = 8'h7B;
      4'd7:    p = 8'hA1;
      4'd8:    p = 8'hFB;
      4'd9:    p = 8'hEB;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/core/ssss_digit_split.sv
// ----------------------------------------------------------------------------
// ssss_digit_split - pipelined decimal digit split
// Saturates a value to 9999 and peels off four decimal digits, one constant
// reciprocal multiply or one multiply-subtract per stage.
// ----------------------------------------------------------------------------
module ssss_digit_split (
  input  logic                            clk,
  input  logic                            en,
  input  logic [ssss_pkg::VALUE_W-1:0]    value,
  output ssss_pkg::digits_t               digits
);

  localparam int DW = ssss_pkg::DIGIT_W;

  // stage 1: saturated value
  logic [13:0]   v1_r, v1_nxt;
  // stage 2: thousands
  logic [13:0]   v2_r;
  logic [DW-1:0] t2_r, t2_nxt;
  logic [27:0]   prod_t;
  // stage 3: remainder below 1000
  logic [DW-1:0] t3_r;
  logic [9:0]    r3_r, r3_nxt;
  logic [13:0]   diff_t;
  // stage 4: hundreds
  logic [DW-1:0] t4_r, h4_r, h4_nxt;
  logic [9:0]    r4_r;
  logic [15:0]   prod_h;
  // stage 5: remainder below 100
  logic [DW-1:0] t5_r, h5_r;
  logic [6:0]    r5_r, r5_nxt;
  logic [9:0]    diff_h;
  // stage 6: tens
  logic [DW-1:0] t6_r, h6_r, n6_r, n6_nxt;
  logic [6:0]    r6_r;
  logic [14:0]   prod_n;
  // stage 7: units
  logic [DW-1:0] t7_r, h7_r, n7_r, u7_r, u7_nxt;
  logic [6:0]    diff_n;

  always_comb begin
    v1_nxt = (value > ssss_pkg::MAX_VALUE) ? ssss_pkg::MAX_VALUE : value;
    prod_t = {14'd0, v1_r} * 28'd8389;
    t2_nxt = prod_t[26:23];
    diff_t = v2_r - ({10'd0, t2_r} * 14'd1000);
    r3_nxt = diff_t[9:0];
    prod_h = {6'd0, r3_r} * 16'd41;
    h4_nxt = prod_h[15:12];
    diff_h = r4_r - ({6'd0, h4_r} * 10'd100);
    r5_nxt = diff_h[6:0];
    prod_n = {8'd0, r5_r} * 15'd205;
    n6_nxt = prod_n[14:11];
    diff_n = r6_r - ({3'd0, n6_r} * 7'd10);
    u7_nxt = diff_n[3:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r <= v1_nxt;
      v2_r <= v1_r;
      t2_r <= t2_nxt;
      t3_r <= t2_r;
      r3_r <= r3_nxt;
      t4_r <= t3_r;
      h4_r <= h4_nxt;
      r4_r <= r3_r;
      t5_r <= t4_r;
      h5_r <= h4_r;
      r5_r <= r5_nxt;
      t6_r <= t5_r;
      h6_r <= h5_r;
      n6_r <= n6_nxt;
      r6_r <= r5_r;
      t7_r <= t6_r;
      h7_r <= h6_r;
      n7_r <= n6_r;
      u7_r <= u7_nxt;
    end
  end

  assign digits.thousands = t7_r;
  assign digits.hundreds  = h7_r;
  assign digits.tens      = n7_r;
  assign digits.units     = u7_r;

endmodule

// File: rtl/core/ssss_frame_build.sv
// ----------------------------------------------------------------------------
// ssss_frame_build - row frame assembly
// Picks the masked segment bit of every digit and packs mask, byte2, byte3.
// ----------------------------------------------------------------------------
module ssss_frame_build (
  input  ssss_pkg::digits_t                 disp_one,
  input  ssss_pkg::digits_t                 disp_two,
  input  ssss_pkg::digits_t                 disp_three,
  input  logic [ssss_pkg::MASK_W-1:0]       row_mask,
  output logic [ssss_pkg::FRAME_BITS-1:0]   frame
);

  // bit order per display: thousands, hundreds, tens, units
  function automatic logic [3:0] lit_bits(input ssss_pkg::digits_t d,
                                          input logic [7:0] m);
    logic [3:0] b;
    b[0] = |(ssss_pkg::seg_pattern(d.thousands) & m);
    b[1] = |((ssss_pkg::seg_pattern(d.hundreds) | ssss_pkg::DP_BIT) & m);
    b[2] = |(ssss_pkg::seg_pattern(d.tens) & m);
    b[3] = |(ssss_pkg::seg_pattern(d.units) & m);
    return b;
  endfunction

  logic [3:0] b_one, b_two, b_three;
  logic [7:0] byte2, byte3;

  always_comb begin
    b_one   = lit_bits(disp_one, row_mask);
    b_two   = lit_bits(disp_two, row_mask);
    b_three = lit_bits(disp_three, row_mask);
    byte3   = {b_two[3], b_two[0], b_two[1], b_two[2], b_one[3:0]};
    byte2   = {b_three[3], b_three[0], b_three[1], b_three[2], 4'b0000};
    frame   = {row_mask, byte2, byte3};
  end

endmodule

// File: rtl/core/ssss_serializer.sv
// ----------------------------------------------------------------------------
// ssss_serializer - frame shifter
// Holds one frame and sends it MSB first, one item per accepted cycle.
// ----------------------------------------------------------------------------
module ssss_serializer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic [ssss_pkg::FRAME_BITS-1:0]   frame,
  output ssss_pkg::ser_status_t             status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_serial_bit,
  output logic [ssss_pkg::POS_W-1:0]        out_bit_position,
  output logic                              out_latch_strobe
);

  localparam int FB = ssss_pkg::FRAME_BITS;

  logic [FB-1:0]               frame_r, frame_nxt;
  logic [ssss_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                        busy_r, busy_nxt;
  logic                        take, last;

  assign last              = (pos_r == ssss_pkg::LAST_POS);
  assign take              = busy_r && out_ready;
  assign status.busy       = busy_r;
  assign status.load_ready = !busy_r || (out_ready && last);

  always_comb begin
    frame_nxt = frame_r;
    pos_nxt   = pos_r;
    busy_nxt  = busy_r;
    if (take) begin
      frame_nxt = {frame_r[FB-2:0], 1'b0};
      pos_nxt   = pos_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      frame_nxt = frame;
      pos_nxt   = '0;
      busy_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
    frame_r <= frame_nxt;
  end

  assign out_valid        = busy_r;
  assign out_serial_bit   = frame_r[FB-1];
  assign out_bit_position = pos_r;
  assign out_latch_strobe = last;

endmodule

// File: rtl/core/seven_segment_scan_serializer_unit.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_serializer_unit - multiplexed seven-segment scan driver
// Turns one scan tick of three display values into a 24-bit serial frame.
// ----------------------------------------------------------------------------
// Each input item carries three display values (saturated to 9999). After a
// fixed seven-stage digit split the item's frame is built against the next
// row of the scan (row counter 1..8, first tick after reset drives row 2)
// and sent MSB first as 24 result items: row mask, byte2, byte3, the last
// item flagged as the latch strobe. The shifter sends one bit per accepted
// cycle and loads the next frame only when idle or as the last bit of the
// current one is taken. An accepted item passes the seven split stages
// and its frame is then loaded into the shifter registers that drive the
// output. Input items are taken in every cycle while the split pipeline
// can move; up to seven items queue in it while a frame is still going out.
// ----------------------------------------------------------------------------
module seven_segment_scan_serializer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ssss_pkg::VALUE_W-1:0]      in_display_one,
  input  logic [ssss_pkg::VALUE_W-1:0]      in_display_two,
  input  logic [ssss_pkg::VALUE_W-1:0]      in_display_three,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_serial_bit,
  output logic [ssss_pkg::POS_W-1:0]        out_bit_position,
  output logic                              out_latch_strobe
);

  localparam int LAT = ssss_pkg::SPLIT_LAT;

  // item valid along the split pipeline
  logic [LAT-1:0]                  vld_r, vld_nxt;
  logic                            en;
  logic                            frame_take;

  // scan row
  logic [ssss_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [ssss_pkg::ROW_W:0]        row_inc;
  logic [ssss_pkg::ROW_W-1:0]      row_sel;
  logic [ssss_pkg::MASK_W-1:0]     row_mask;

  ssss_pkg::digits_t               dig_one, dig_two, dig_three;
  logic [ssss_pkg::FRAME_BITS-1:0] frame;
  ssss_pkg::ser_status_t           ser_st;

  // whole split pipeline moves together; it stalls only when its last
  // stage holds an item the shifter cannot take yet
  assign frame_take = vld_r[LAT-1] && ser_st.load_ready;
  assign en         = !vld_r[LAT-1] || frame_take;
  assign in_ready   = en;

  always_comb begin
    vld_nxt = vld_r;
    if (en) begin
      vld_nxt = {vld_r[LAT-2:0], in_valid};
    end
  end

  // row advances before use; out-of-range wraps to the first row
  always_comb begin
    row_inc = {1'b0, row_r} + 1'b1;
    if (row_inc == '0 || row_inc > {1'b0, ssss_pkg::ROW_LAST}) begin
      row_sel = ssss_pkg::ROW_FIRST;
    end else begin
      row_sel = row_inc[ssss_pkg::ROW_W-1:0];
    end
    row_mask = ssss_pkg::MASK_W'(1) << (row_sel - 1'b1);
    row_nxt  = frame_take ? row_sel : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      row_r <= ssss_pkg::ROW_FIRST;
    end else begin
      vld_r <= vld_nxt;
      row_r <= row_nxt;
    end
  end

  ssss_digit_split u_split_one (
    .clk    (clk),
    .en     (en),
    .value  (in_display_one),
    .digits (dig_one)
  );

  ssss_digit_split u_split_two (
    .clk    (clk),
    .en     (en),
    .value  (in_display_two),
    .digits (dig_two)
  );

  ssss_digit_split u_split_three (
    .clk    (clk),
    .en     (en),
    .value  (in_display_three),
    .digits (dig_three)
  );

  ssss_frame_build u_frame (
    .disp_one   (dig_one),
    .disp_two   (dig_two),
    .disp_three (dig_three),
    .row_mask   (row_mask),
    .frame      (frame)
  );

  ssss_serializer u_ser (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (frame_take),
    .frame            (frame),
    .status           (ser_st),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_serial_bit   (out_serial_bit),
    .out_bit_position (out_bit_position),
    .out_latch_strobe (out_latch_strobe)
  );

  // strobe marks the final bit of the frame and nothing else
  a_strobe_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_latch_strobe == (out_bit_position == ssss_pkg::LAST_POS)))
    else $error("latch strobe off the last bit");

  // a frame is never cut short: a taken mid-frame bit is followed by the next
  a_frame_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_latch_strobe |=>
      out_valid && (out_bit_position == $past(out_bit_position) + 1'b1))
    else $error("frame broken off");

  // row counter stays within the eight scan rows
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r >= ssss_pkg::ROW_FIRST) && (row_r <= ssss_pkg::ROW_LAST))
    else $error("row counter out of range");

  // an accepted item enters the split pipeline
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted item lost");

endmodule
